/* sv/ros_pkg.sv */
// ros_pkg: shared types and constants for the oriented rectangle overlap test
// holds the input pair and result struct types used by rect_overlap_sat
// no dependencies
package ros_pkg;

    localparam int IN_WORD_W      = 32;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int NUM_AXES       = 4;
    localparam int NUM_CORNERS    = 8;

    typedef struct packed {
        logic [IN_WORD_W-1:0] first_corner_a;
        logic [IN_WORD_W-1:0] first_corner_b;
        logic [IN_WORD_W-1:0] first_corner_c;
        logic [IN_WORD_W-1:0] first_corner_d;
        logic [IN_WORD_W-1:0] second_corner_a;
        logic [IN_WORD_W-1:0] second_corner_b;
        logic [IN_WORD_W-1:0] second_corner_c;
        logic [IN_WORD_W-1:0] second_corner_d;
    } pair_t;

    typedef struct packed {
        logic                overlapping;
        logic [NUM_AXES-1:0] axis_overlap_mask;
    } result_t;

endpackage

/* sv/ros_axis.sv */
// ros_axis: projects eight corners onto one test axis and compares the two intervals
// four register stages: products, dot sums, pairwise min/max, interval extents
// depends on ros_pkg
module ros_axis
    import ros_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic signed [COORD_WIDTH-1:0] cx [NUM_CORNERS],
    input  logic signed [COORD_WIDTH-1:0] cy [NUM_CORNERS],
    input  logic signed [COORD_WIDTH:0]   ax,
    input  logic signed [COORD_WIDTH:0]   ay,
    input  logic                          axis_zero,
    output logic                          hit
);

    localparam int PROD_W = 2 * COORD_WIDTH + 1;
    localparam int PROJ_W = 2 * COORD_WIDTH + 2;

    logic signed [PROD_W-1:0] px_reg [NUM_CORNERS];
    logic signed [PROD_W-1:0] py_reg [NUM_CORNERS];
    logic signed [PROJ_W-1:0] dot_reg [NUM_CORNERS];
    logic signed [PROJ_W-1:0] lo_pair_reg [4];
    logic signed [PROJ_W-1:0] hi_pair_reg [4];
    logic signed [PROJ_W-1:0] lo_reg [2];
    logic signed [PROJ_W-1:0] hi_reg [2];
    logic [3:0]               zero_reg;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_CORNERS; k++)
        begin
            px_reg[k]  <= PROD_W'(cx[k]) * PROD_W'(ax);
            py_reg[k]  <= PROD_W'(cy[k]) * PROD_W'(ay);
            dot_reg[k] <= PROJ_W'(px_reg[k]) + PROJ_W'(py_reg[k]);
        end
        // pairs of corners within each rectangle
        for (int p = 0; p < 4; p++)
        begin
            if (dot_reg[2*p] < dot_reg[2*p+1])
            begin
                lo_pair_reg[p] <= dot_reg[2*p];
                hi_pair_reg[p] <= dot_reg[2*p+1];
            end
            else
            begin
                lo_pair_reg[p] <= dot_reg[2*p+1];
                hi_pair_reg[p] <= dot_reg[2*p];
            end
        end
        for (int r = 0; r < 2; r++)
        begin
            lo_reg[r] <= (lo_pair_reg[2*r] < lo_pair_reg[2*r+1]) ?
                         lo_pair_reg[2*r] : lo_pair_reg[2*r+1];
            hi_reg[r] <= (hi_pair_reg[2*r] > hi_pair_reg[2*r+1]) ?
                         hi_pair_reg[2*r] : hi_pair_reg[2*r+1];
        end
        zero_reg <= {zero_reg[2:0], axis_zero};
    end

    // closed intervals, a zero-length axis never overlaps
    assign hit = !zero_reg[3] && (lo_reg[0] <= hi_reg[1]) && (hi_reg[0] >= lo_reg[1]);

endmodule

/* sv/rect_overlap_sat.sv */
// rect_overlap_sat: separating axis overlap test for two oriented rectangles
// input regs, four axis stages, result reg to done; throughput: one item every cycle
// the four axis units run in parallel, each a four-stage multiply/add/compare pipeline
// busy stays low; results cannot be stalled and leave on done for one cycle
// reset clears the valid pipeline only; data registers are not reset
module rect_overlap_sat
    import ros_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  pair_t   pair,
    output logic    done,
    output result_t result
);

    localparam int AX_W    = COORD_WIDTH + 1;
    localparam int LATENCY = 6;

    logic [IN_WORD_W-1:0]          words [NUM_CORNERS];
    logic [2*IN_WORD_W-1:0]        wide  [NUM_CORNERS];
    logic signed [COORD_WIDTH-1:0] cx_next [NUM_CORNERS];
    logic signed [COORD_WIDTH-1:0] cy_next [NUM_CORNERS];
    logic signed [COORD_WIDTH-1:0] cx_reg  [NUM_CORNERS];
    logic signed [COORD_WIDTH-1:0] cy_reg  [NUM_CORNERS];
    logic signed [AX_W-1:0]        ax_next [NUM_AXES];
    logic signed [AX_W-1:0]        ay_next [NUM_AXES];
    logic signed [AX_W-1:0]        ax_reg  [NUM_AXES];
    logic signed [AX_W-1:0]        ay_reg  [NUM_AXES];
    logic [NUM_AXES-1:0]           zero_next;
    logic [NUM_AXES-1:0]           zero_reg;
    logic [NUM_AXES-1:0]           hit;
    logic [LATENCY-1:0]            valid_reg;
    logic [LATENCY-1:0]            valid_next;
    result_t                       result_reg;
    result_t                       result_next;

    assign words[0] = pair.first_corner_a;
    assign words[1] = pair.first_corner_b;
    assign words[2] = pair.first_corner_c;
    assign words[3] = pair.first_corner_d;
    assign words[4] = pair.second_corner_a;
    assign words[5] = pair.second_corner_b;
    assign words[6] = pair.second_corner_c;
    assign words[7] = pair.second_corner_d;

    // y bits above the input word read as zero
    always_comb
    begin
        for (int k = 0; k < NUM_CORNERS; k++)
        begin
            wide[k]    = {{IN_WORD_W{1'b0}}, words[k]};
            cx_next[k] = signed'(wide[k][COORD_WIDTH-1:0]);
            cy_next[k] = signed'(wide[k][2*COORD_WIDTH-1:COORD_WIDTH]);
        end
        // axes: a-d and a-b of each rectangle
        for (int r = 0; r < 2; r++)
        begin
            ax_next[2*r]   = AX_W'(cx_next[4*r]) - AX_W'(cx_next[4*r+3]);
            ay_next[2*r]   = AX_W'(cy_next[4*r]) - AX_W'(cy_next[4*r+3]);
            ax_next[2*r+1] = AX_W'(cx_next[4*r]) - AX_W'(cx_next[4*r+1]);
            ay_next[2*r+1] = AX_W'(cy_next[4*r]) - AX_W'(cy_next[4*r+1]);
        end
        for (int a = 0; a < NUM_AXES; a++)
        begin
            zero_next[a] = (ax_next[a] == '0) && (ay_next[a] == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        zero_reg <= zero_next;
        result_reg <= result_next;
    end

    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_axis
        ros_axis #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_axis (
            .clk       (clk),
            .cx        (cx_reg),
            .cy        (cy_reg),
            .ax        (ax_reg[a]),
            .ay        (ay_reg[a]),
            .axis_zero (zero_reg[a]),
            .hit       (hit[a])
        );
    end

    always_comb
    begin
        result_next.axis_overlap_mask = hit;
        result_next.overlapping       = &hit;
        valid_next = {valid_reg[LATENCY-2:0], start && !busy};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign busy   = 1'b0;
    assign done   = valid_reg[LATENCY-1];
    assign result = result_reg;

    a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##6 done)
        else $error("accepted item did not produce done after six cycles");

    a_done_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 6))
        else $error("done without an item accepted six cycles before");

    a_overlap_all_axes: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.overlapping == (result.axis_overlap_mask == {NUM_AXES{1'b1}})))
        else $error("overlapping flag disagrees with the axis mask");

endmodule
